FILE: hdl/sfm_pkg.sv
// ----------------------------------------------------------------------------
// sfm_pkg
// Shared types and constants of the substring first-match unit: opcodes,
// default sizes and the control bundle that drives the compare cells.
// ----------------------------------------------------------------------------
package sfm_pkg;

    localparam int DEFAULT_MAX_PATTERN_LEN = 64;
    localparam int DEFAULT_MAX_TEXT_LEN    = 65536;

    localparam int OPCODE_W   = 2;
    localparam int BYTE_W     = 8;
    localparam int POS_OUT_W  = 16;

    typedef enum logic [OPCODE_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_TEXT   = 2'd2,
        OP_END    = 2'd3
    } sfm_opcode_t;

    typedef struct packed {
        logic clear_tail;
        logic load;
        logic text_en;
        logic restart;
    } sfm_ctrl_t;

endpackage

FILE: hdl/sfm_cell.sv
// ----------------------------------------------------------------------------
// sfm_cell
// One compare cell: holds one pattern byte, its partial-match bit and a tail
// mark for the last loaded pattern byte. Takes the match bit and tail mark
// of its lower neighbor.
// ----------------------------------------------------------------------------
module sfm_cell
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  sfm_pkg::sfm_ctrl_t          ctrl,
    input  logic [sfm_pkg::BYTE_W-1:0]  data_byte,
    input  logic                        prev_match,
    input  logic                        prev_tail,
    output logic                        match,
    output logic                        tail,
    output logic                        hit
);

    logic [sfm_pkg::BYTE_W-1:0] pat_reg;
    logic                       match_reg;
    logic                       match_next;
    logic                       tail_reg;
    logic                       tail_next;
    logic                       byte_eq;

    assign byte_eq = (pat_reg == data_byte);

    always_comb
    begin
        match_next = match_reg;
        tail_next  = tail_reg;
        if (ctrl.restart)
        begin
            match_next = 1'b0;
        end
        else if (ctrl.text_en)
        begin
            match_next = prev_match & byte_eq;
        end
        if (ctrl.clear_tail)
        begin
            tail_next = 1'b0;
        end
        else if (ctrl.load)
        begin
            tail_next = prev_tail;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
            tail_reg  <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
            tail_reg  <= tail_next;
        end
    end

    // load the byte into the cell that becomes the new tail
    always_ff @(posedge clk)
    begin
        if (ctrl.load && prev_tail)
        begin
            pat_reg <= data_byte;
        end
    end

    assign match = match_reg;
    assign tail  = tail_reg;
    assign hit   = ctrl.text_en & tail_reg & prev_match & byte_eq;

endmodule

FILE: hdl/substring_first_match_unit.sv
// ----------------------------------------------------------------------------
// substring_first_match_unit
// Streaming search for the first occurrence of a loaded pattern in a text.
//
// Input channel (in_valid/in_ready, opcode, data_byte): one transaction per
// opcode. Clear and append load the pattern, one byte per transaction, and
// restart the current text. Text bytes advance a row of compare cells, one
// per pattern byte, each cell handing its match bit to the next.
// End of text produces one result transaction on the output channel
// (out_valid/out_ready, found, match_position, text_overflow) from the
// output register once it is accepted; other opcodes produce no result.
// Throughput: one transaction per cycle for every opcode unless stalled, set
// by the single compare step of the cell row. The result sits in an output
// register; while it is held and out_ready is low, in_ready is low and the
// input stalls for every opcode. A held result and a new end of text pass in
// the same cycle. Reset clears the pattern length, the text state and the
// result valid flag; pattern bytes are loaded again before use.
// ----------------------------------------------------------------------------
module substring_first_match_unit
#(
    parameter int MAX_PATTERN_LEN = sfm_pkg::DEFAULT_MAX_PATTERN_LEN,
    parameter int MAX_TEXT_LEN    = sfm_pkg::DEFAULT_MAX_TEXT_LEN
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [sfm_pkg::OPCODE_W-1:0]   opcode,
    input  logic [sfm_pkg::BYTE_W-1:0]     data_byte,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           found,
    output logic [sfm_pkg::POS_OUT_W-1:0]  match_position,
    output logic                           text_overflow
);

    localparam int LEN_W = $clog2(MAX_PATTERN_LEN + 1);
    localparam int POS_W = $clog2(MAX_TEXT_LEN + 1);

    logic                            accept;
    logic                            op_clear;
    logic                            op_append;
    logic                            op_text;
    logic                            op_end;
    logic                            pat_full;
    logic                            text_full;
    logic                            len_zero;
    logic                            any_hit;
    sfm_pkg::sfm_ctrl_t              ctrl;

    logic [MAX_PATTERN_LEN-1:0]      cell_match;
    logic [MAX_PATTERN_LEN-1:0]      cell_tail;
    logic [MAX_PATTERN_LEN-1:0]      cell_hit;

    logic [LEN_W-1:0]                length_reg;
    logic [LEN_W-1:0]                length_next;
    logic [POS_W-1:0]                pos_reg;
    logic [POS_W-1:0]                pos_next;
    logic                            found_flag_reg;
    logic                            found_flag_next;
    logic [sfm_pkg::POS_OUT_W-1:0]   start_reg;
    logic [sfm_pkg::POS_OUT_W-1:0]   start_next;
    logic                            ovf_reg;
    logic                            ovf_next;
    logic [sfm_pkg::POS_OUT_W-1:0]   start_calc;

    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic                            found_reg;
    logic [sfm_pkg::POS_OUT_W-1:0]   position_reg;
    logic                            overflow_reg;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign pat_full  = (length_reg == LEN_W'(MAX_PATTERN_LEN));
    assign text_full = (pos_reg == POS_W'(MAX_TEXT_LEN));
    assign len_zero  = (length_reg == '0);
    assign any_hit   = |cell_hit;

    always_comb
    begin
        op_clear  = 1'b0;
        op_append = 1'b0;
        op_text   = 1'b0;
        op_end    = 1'b0;
        unique case (sfm_pkg::sfm_opcode_t'(opcode))
            sfm_pkg::OP_CLEAR:  op_clear  = 1'b1;
            sfm_pkg::OP_APPEND: op_append = 1'b1;
            sfm_pkg::OP_TEXT:   op_text   = 1'b1;
            sfm_pkg::OP_END:    op_end    = 1'b1;
            default:            op_end    = 1'b0;
        endcase
    end

    always_comb
    begin
        ctrl.clear_tail = accept && op_clear;
        ctrl.load       = accept && op_append && !pat_full;
        ctrl.text_en    = accept && op_text && !text_full;
        ctrl.restart    = accept && (op_clear || op_append || op_end);
    end

    genvar k;
    generate
        for (k = 0; k < MAX_PATTERN_LEN; k++)
        begin : g_cell
            logic prev_match;
            logic prev_tail;
            if (k == 0)
            begin : g_first
                assign prev_match = 1'b1;
                assign prev_tail  = len_zero;
            end
            else
            begin : g_rest
                assign prev_match = cell_match[k-1];
                assign prev_tail  = cell_tail[k-1];
            end
            sfm_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .data_byte  (data_byte),
                .prev_match (prev_match),
                .prev_tail  (prev_tail),
                .match      (cell_match[k]),
                .tail       (cell_tail[k]),
                .hit        (cell_hit[k])
            );
        end
    endgenerate

    assign start_calc = sfm_pkg::POS_OUT_W'(pos_reg) + sfm_pkg::POS_OUT_W'(1)
                        - sfm_pkg::POS_OUT_W'(length_reg);

    always_comb
    begin
        length_next     = length_reg;
        pos_next        = pos_reg;
        found_flag_next = found_flag_reg;
        start_next      = start_reg;
        ovf_next        = ovf_reg;
        if (ctrl.restart)
        begin
            pos_next        = '0;
            found_flag_next = 1'b0;
            start_next      = '0;
            ovf_next        = 1'b0;
        end
        if (ctrl.clear_tail)
        begin
            length_next = '0;
        end
        else if (ctrl.load)
        begin
            length_next = length_reg + LEN_W'(1);
        end
        if (accept && op_text)
        begin
            if (text_full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
                if (any_hit && !found_flag_reg)
                begin
                    found_flag_next = 1'b1;
                    start_next      = start_calc;
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept && op_end)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg     <= '0;
            pos_reg        <= '0;
            found_flag_reg <= 1'b0;
            start_reg      <= '0;
            ovf_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            length_reg     <= length_next;
            pos_reg        <= pos_next;
            found_flag_reg <= found_flag_next;
            start_reg      <= start_next;
            ovf_reg        <= ovf_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // hold the result until taken
    always_ff @(posedge clk)
    begin
        if (accept && op_end)
        begin
            found_reg    <= len_zero || found_flag_reg;
            position_reg <= (!len_zero && found_flag_reg) ? start_reg : '0;
            overflow_reg <= ovf_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign found          = found_reg;
    assign match_position = position_reg;
    assign text_overflow  = overflow_reg;

endmodule

FILE: verif/tb_substring_first_match_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_substring_first_match_unit
// Self-checking bench for the substring first-match unit. A shift-and
// predictor tracks the pattern and the running text. It queues the result
// of every end of text, and each result the unit returns is compared with
// it. Stimulus: directed corner cases, an overfilled pattern, then random
// pattern/text searches with noise, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_substring_first_match_unit;

    localparam int PAT_MAX        = sfm_pkg::DEFAULT_MAX_PATTERN_LEN;
    localparam int TEXT_MAX       = sfm_pkg::DEFAULT_MAX_TEXT_LEN;
    localparam int RANDOM_ITEMS   = 1680;
    localparam int STALL_LIMIT    = 5000;

    typedef struct {
        logic        found;
        logic [15:0] position;
        logic        overflow;
    } search_result_t;

    class first_match_scoreboard;
        logic [7:0]         pat_bytes [PAT_MAX];
        int                 pat_len;
        logic [PAT_MAX-1:0] prefix_hits;
        int                 text_pos;
        bit                 hit_seen;
        int                 hit_start;
        bit                 text_over;
        search_result_t     result_q [$];
        int                 errors;
        int                 checked;

        function new();
            pat_len = 0;
            errors  = 0;
            checked = 0;
            restart_text();
        endfunction

        function void restart_text();
            prefix_hits = '0;
            text_pos    = 0;
            hit_seen    = 1'b0;
            hit_start   = 0;
            text_over   = 1'b0;
        endfunction

        function int pending();
            return result_q.size();
        endfunction

        function void note_input(sfm_pkg::sfm_opcode_t op, logic [7:0] b);
            logic [PAT_MAX-1:0] byte_eq;
            search_result_t     r;
            case (op)
                sfm_pkg::OP_CLEAR:
                begin
                    pat_len = 0;
                    restart_text();
                end
                sfm_pkg::OP_APPEND:
                begin
                    if (pat_len < PAT_MAX)
                    begin
                        pat_bytes[pat_len] = b;
                        pat_len++;
                    end
                    restart_text();
                end
                sfm_pkg::OP_TEXT:
                begin
                    if (text_pos >= TEXT_MAX)
                    begin
                        text_over = 1'b1;
                    end
                    else
                    begin
                        for (int k = 0; k < PAT_MAX; k++)
                            byte_eq[k] = (k < pat_len) && (pat_bytes[k] == b);
                        prefix_hits = ((prefix_hits << 1) | PAT_MAX'(1)) & byte_eq;
                        if (pat_len > 0 && !hit_seen && prefix_hits[pat_len-1])
                        begin
                            hit_seen  = 1'b1;
                            hit_start = text_pos + 1 - pat_len;
                        end
                        text_pos++;
                    end
                end
                default:
                begin
                    r.found    = (pat_len == 0) || hit_seen;
                    r.position = (pat_len != 0 && hit_seen) ? hit_start[15:0] : 16'd0;
                    r.overflow = text_over;
                    result_q.push_back(r);
                    restart_text();
                end
            endcase
        endfunction

        function void check_result(logic f, logic [15:0] p, logic o);
            search_result_t want;
            checked++;
            if (result_q.size() == 0)
            begin
                errors++;
                $error("result with none pending: found=%0d match_position=%0d %s=%0d",
                       f, p, "text_overflow", o);
                return;
            end
            want = result_q.pop_front();
            if (f !== want.found)
            begin
                errors++;
                $error("found: expected %0d, actual %0d", want.found, f);
            end
            if (p !== want.position)
            begin
                errors++;
                $error("match_position: expected %0d, actual %0d", want.position, p);
            end
            if (o !== want.overflow)
            begin
                errors++;
                $error("text_overflow: expected %0d, actual %0d", want.overflow, o);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  opcode = sfm_pkg::OP_CLEAR;
    logic [7:0]  data_byte = 8'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        found;
    logic [15:0] match_position;
    logic        text_overflow;

    first_match_scoreboard sb;
    bit idle_on = 1'b1;
    int sent_count = 0;
    int stall_cycles = 0;

    substring_first_match_unit
    #(
        .MAX_PATTERN_LEN (PAT_MAX),
        .MAX_TEXT_LEN    (TEXT_MAX)
    )
    dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .found          (found),
        .match_position (match_position),
        .text_overflow  (text_overflow)
    );

    always #6 clk = ~clk;

    always @(negedge clk)
    begin
        out_ready <= !idle_on || ($urandom_range(99) >= 9);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_result(found, match_position, text_overflow);
            if (in_valid && in_ready)
                sb.note_input(sfm_pkg::sfm_opcode_t'(opcode), data_byte);
            if ((out_valid && out_ready) || (in_valid && in_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("tb_substring_first_match_unit: FAIL");
                $finish;
            end
        end
    end

    // call and return at a falling edge; valid stays up between transactions unless an idle gap is drawn
    task automatic push_item(input sfm_pkg::sfm_opcode_t op, input logic [7:0] b);
        while (idle_on && $urandom_range(99) < 9)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        opcode    <= op;
        data_byte <= b;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        sent_count++;
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    task automatic run_random_search();
        logic [7:0] alpha [2];
        logic [7:0] pat_q [$];
        logic [7:0] txt [$];
        logic [7:0] b;
        logic [1:0] opv;
        bit         cleared;
        bit         full_range;
        int         r;
        int         plen;
        int         tlen;
        r = $urandom_range(99);
        if (r < 10)
        begin
            repeat ($urandom_range(1, 6))
            begin
                opv = 2'($urandom_range(3));
                push_item(sfm_pkg::sfm_opcode_t'(opv), 8'($urandom_range(255)));
            end
            return;
        end
        alpha[0]   = 8'($urandom_range(255));
        alpha[1]   = 8'($urandom_range(255));
        full_range = ($urandom_range(4) == 0);
        cleared    = ($urandom_range(4) != 0);
        if (cleared)
            push_item(sfm_pkg::OP_CLEAR, 8'($urandom_range(255)));
        r = $urandom_range(99);
        plen = (r < 55) ? $urandom_range(0, 3) :
               (r < 90) ? $urandom_range(4, 8) : $urandom_range(9, 70);
        for (int i = 0; i < plen; i++)
        begin
            b = full_range ? 8'($urandom_range(255)) : alpha[$urandom_range(1)];
            push_item(sfm_pkg::OP_APPEND, b);
            pat_q.push_back(b);
        end
        tlen = ($urandom_range(9) == 0) ? $urandom_range(30, 100) : $urandom_range(0, 24);
        while (txt.size() < tlen)
        begin
            if (cleared && pat_q.size() > 0 && $urandom_range(3) == 0)
                txt = {txt, pat_q};
            else
                txt.push_back(full_range ? 8'($urandom_range(255)) : alpha[$urandom_range(1)]);
        end
        foreach (txt[i])
        begin
            if ($urandom_range(99) == 0)
            begin
                opv = 2'($urandom_range(1));
                push_item(sfm_pkg::sfm_opcode_t'(opv), alpha[$urandom_range(1)]);
            end
            push_item(sfm_pkg::OP_TEXT, txt[i]);
        end
        push_item(sfm_pkg::OP_END, 8'($urandom_range(255)));
    endtask

    initial
    begin
        logic [7:0] big_pat [66];
        int         random_start;
        sb = new();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        push_item(sfm_pkg::OP_END, 8'hFF);
        push_item(sfm_pkg::OP_TEXT, 8'h00);
        push_item(sfm_pkg::OP_TEXT, 8'hFF);
        push_item(sfm_pkg::OP_END, 8'h00);
        push_item(sfm_pkg::OP_CLEAR, 8'hFF);
        push_item(sfm_pkg::OP_APPEND, 8'hFF);
        push_item(sfm_pkg::OP_APPEND, 8'h00);
        push_item(sfm_pkg::OP_TEXT, 8'h00);
        push_item(sfm_pkg::OP_TEXT, 8'hFF);
        push_item(sfm_pkg::OP_TEXT, 8'h00);
        push_item(sfm_pkg::OP_TEXT, 8'hFF);
        push_item(sfm_pkg::OP_TEXT, 8'h00);
        push_item(sfm_pkg::OP_END, 8'hFF);
        push_item(sfm_pkg::OP_APPEND, 8'h55);
        push_item(sfm_pkg::OP_TEXT, 8'hFF);
        push_item(sfm_pkg::OP_TEXT, 8'h00);
        push_item(sfm_pkg::OP_END, 8'h00);
        push_item(sfm_pkg::OP_TEXT, 8'hFF);
        push_item(sfm_pkg::OP_APPEND, 8'hAA);
        push_item(sfm_pkg::OP_TEXT, 8'hFF);
        push_item(sfm_pkg::OP_TEXT, 8'h00);
        push_item(sfm_pkg::OP_TEXT, 8'h55);
        push_item(sfm_pkg::OP_TEXT, 8'hAA);
        push_item(sfm_pkg::OP_END, 8'h00);
        push_item(sfm_pkg::OP_TEXT, 8'h12);
        push_item(sfm_pkg::OP_CLEAR, 8'h00);
        push_item(sfm_pkg::OP_END, 8'h00);

        // overfill the pattern; the last two appends drop
        push_item(sfm_pkg::OP_CLEAR, 8'h00);
        foreach (big_pat[i])
        begin
            big_pat[i] = 8'($urandom_range(255));
            push_item(sfm_pkg::OP_APPEND, big_pat[i]);
        end
        repeat (3) push_item(sfm_pkg::OP_TEXT, 8'($urandom_range(255)));
        for (int i = 0; i < PAT_MAX; i++)
            push_item(sfm_pkg::OP_TEXT, big_pat[i]);
        push_item(sfm_pkg::OP_END, 8'h00);
        wait_for_results();

        random_start = sent_count;
        while (sent_count - random_start < RANDOM_ITEMS)
        begin
            idle_on = !((sent_count - random_start >= 600) &&
                        (sent_count - random_start < 1000));
            run_random_search();
            if ($urandom_range(39) == 0)
                wait_for_results();
        end
        idle_on = 1'b1;

        wait_for_results();
        repeat (4) @(negedge clk);
        $display("Ran %0d input transactions and checked %0d search results,",
                 sent_count, sb.checked);
        $display("covering empty/overfilled patterns, pattern changes and short texts.");
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_substring_first_match_unit: PASS");
        else
            $display("tb_substring_first_match_unit: FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/sfm_pkg.sv
hdl/sfm_cell.sv
hdl/substring_first_match_unit.sv
verif/tb_substring_first_match_unit.sv
